// File: sv/fre_pkg.sv
// Package of the fragment reassembly engine: codes, payload types and sizes.
`default_nettype none

package fre_pkg;

  // Default size of the reassembly store in bytes.
  localparam int unsigned StoreBytesDefault = 4096;

  // Transaction kinds on the input channel.
  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_READ    = 2'd2,
    KIND_RELEASE = 2'd3
  } kind_e;

  // Fragment types carried in a header; higher codes are invalid.
  localparam logic [2:0] FT_START_END = 3'd0;
  localparam logic [2:0] FT_START     = 3'd1;
  localparam logic [2:0] FT_MID       = 3'd2;
  localparam logic [2:0] FT_END       = 3'd3;

  // Result status codes.
  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_UNREADABLE = 4'd1,
    ST_SEQ        = 4'd2,
    ST_SUBSEQ     = 4'd3,
    ST_MISMATCH   = 4'd4,
    ST_TOTAL      = 4'd5,
    ST_OVERFLOW   = 4'd6,
    ST_BAD_TYPE   = 4'd7,
    ST_TOO_LARGE  = 4'd8,
    ST_IGNORED    = 4'd9
  } status_e;

  // One input item.
  typedef struct packed {
    logic [1:0]  kind;
    logic        header_ok;
    logic [2:0]  frag_class;
    logic [15:0] seq_number;
    logic [15:0] sub_seq_number;
    logic [31:0] total_length;
    logic [31:0] payload_length;
    logic [7:0]  data_byte;
    logic [11:0] read_index;
  } fre_in_t;

  // One result item.
  typedef struct packed {
    status_e     status;
    logic        message_ready;
    logic [12:0] message_length;
    logic [7:0]  read_data;
  } fre_out_t;

endpackage

`default_nettype wire

// File: sv/fre_stream_if.sv
// Valid/ready stream interface used by both channels of the reassembly engine.
`default_nettype none

interface fre_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: sv/fragment_reassembly_engine.sv
// Top level of the fragment reassembly engine: header checks, store and read-out.
`default_nettype none

// While out_o is ready, the engine takes one transaction per cycle on in_i (headers,
// payload bytes, reads and releases) and gives exactly one result transaction for
// each on out_o, from a register loaded at acceptance. The control state sits in
// flip-flops and is updated at the acceptance edge; payload bytes are written into a
// STORE_BYTES x 8 single-port style memory, and a read is served by that memory's
// registered read port, loaded with the output register. With out_o ready the
// sustained rate is one transaction per clock; a stalled output holds the input
// for as long as the result register stays full. The store is not cleared after
// reset: bytes that were never written are never reported, since a read is only
// accepted below the write pointer of the current message.
module fragment_reassembly_engine
  import fre_pkg::*;
#(
  parameter int unsigned STORE_BYTES = StoreBytesDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  fre_stream_if.sink   in_i,
  fre_stream_if.source out_o
);

  localparam int unsigned CW = $clog2(STORE_BYTES + 1);
  localparam int unsigned AW = $clog2(STORE_BYTES);

  // Control state.
  logic          waiting_q, waiting_d;
  logic          buffer_held_q, buffer_held_d;
  logic [15:0]   expected_seq_q, expected_seq_d;
  logic [15:0]   expected_sub_seq_q, expected_sub_seq_d;
  logic [CW-1:0] held_total_q, held_total_d;
  logic [CW-1:0] write_pointer_q, write_pointer_d;
  logic [CW-1:0] bytes_pending_q, bytes_pending_d;

  // Output register.
  logic          out_valid_q;
  fre_out_t      out_q, out_d;
  logic          rd_hit_q;

  // Store and its ports.
  logic [7:0]    message_store [STORE_BYTES];
  logic [7:0]    rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_raddr;

  fre_in_t       item;
  logic          accept;
  logic          rd_hit;
  status_e       status;
  logic          first_frag;
  logic [CW-1:0] room;
  logic [16:0]   sub_next;
  logic          sub_ok;

  assign item   = in_i.payload;
  assign accept = in_i.valid && in_i.ready;

  // The input is taken whenever the result register is empty or being emptied.
  assign in_i.ready = !out_valid_q || out_o.ready;

  assign sub_next = {1'b0, expected_sub_seq_q} + 17'd1;
  assign sub_ok   = (expected_sub_seq_q == 16'd0 && item.sub_seq_number == 16'd0) ||
                    (sub_next == {1'b0, item.sub_seq_number});
  assign first_frag = (item.frag_class == FT_START_END) || (item.frag_class == FT_START);
  // Room left in the message; a first fragment sizes it from its own total.
  assign room = buffer_held_q ? (held_total_q - write_pointer_q)
                              : CW'(item.total_length);
  assign mem_raddr = AW'(item.read_index);

  // Next-state logic for one accepted transaction.
  always_comb begin
    waiting_d          = waiting_q;
    buffer_held_d      = buffer_held_q;
    expected_seq_d     = expected_seq_q;
    expected_sub_seq_d = expected_sub_seq_q;
    held_total_d       = held_total_q;
    write_pointer_d    = write_pointer_q;
    bytes_pending_d    = bytes_pending_q;
    status             = ST_OK;
    mem_we             = 1'b0;
    rd_hit             = 1'b0;

    unique case (item.kind)
      KIND_HEADER: begin
        // Bytes left over from the previous fragment are dropped.
        bytes_pending_d = '0;
        if (!item.header_ok) begin
          status = ST_UNREADABLE;
        end else if (item.seq_number != expected_seq_q) begin
          status = ST_SEQ;
        end else if (!sub_ok) begin
          status = ST_SUBSEQ;
        end else if (item.frag_class > FT_END) begin
          status = ST_BAD_TYPE;
        end else begin
          if (first_frag ? (buffer_held_q || waiting_q)
                         : (!buffer_held_q || !waiting_q)) begin
            status = ST_MISMATCH;
          end else if (!buffer_held_q && item.total_length > 32'(STORE_BYTES)) begin
            status = ST_TOO_LARGE;
          end else if (buffer_held_q && 32'(held_total_q) != item.total_length) begin
            status = ST_TOTAL;
          end else if (item.payload_length > 32'(room)) begin
            status = ST_OVERFLOW;
          end
          if (status != ST_OK) begin
            // Every error from here on abandons the message.
            waiting_d          = 1'b0;
            buffer_held_d      = 1'b0;
            expected_seq_d     = '0;
            expected_sub_seq_d = '0;
            held_total_d       = '0;
            write_pointer_d    = '0;
            bytes_pending_d    = '0;
          end else begin
            if (!buffer_held_q) begin
              buffer_held_d   = 1'b1;
              held_total_d    = CW'(item.total_length);
              write_pointer_d = '0;
            end
            bytes_pending_d = CW'(item.payload_length);
            if (item.frag_class == FT_START) begin
              waiting_d          = 1'b1;
              expected_seq_d     = item.seq_number;
              expected_sub_seq_d = item.sub_seq_number;
            end else if (item.frag_class == FT_MID) begin
              expected_seq_d     = item.seq_number;
              expected_sub_seq_d = item.sub_seq_number;
            end else if (item.frag_class == FT_END) begin
              waiting_d = 1'b0;
            end
          end
        end
      end
      KIND_PAYLOAD: begin
        if (bytes_pending_q != '0 && 32'(write_pointer_q) < 32'(STORE_BYTES)) begin
          mem_we          = 1'b1;
          write_pointer_d = write_pointer_q + CW'(1);
          bytes_pending_d = bytes_pending_q - CW'(1);
        end else begin
          status = ST_IGNORED;
        end
      end
      KIND_READ: begin
        if (buffer_held_q && !waiting_q &&
            32'(item.read_index) < 32'(write_pointer_q) &&
            32'(item.read_index) < 32'(STORE_BYTES)) begin
          rd_hit = 1'b1;
        end else begin
          status = ST_IGNORED;
        end
      end
      KIND_RELEASE: begin
        if (buffer_held_q && !waiting_q) begin
          waiting_d          = 1'b0;
          buffer_held_d      = 1'b0;
          expected_seq_d     = '0;
          expected_sub_seq_d = '0;
          held_total_d       = '0;
          write_pointer_d    = '0;
          bytes_pending_d    = '0;
        end else begin
          status = ST_IGNORED;
        end
      end
      default: begin
        status = ST_IGNORED;
      end
    endcase

    out_d.status         = status;
    out_d.message_ready  = buffer_held_d && !waiting_d;
    out_d.message_length = 13'(write_pointer_d);
    out_d.read_data      = '0;
  end

  assign mem_re = accept && rd_hit;

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q          <= 1'b0;
      buffer_held_q      <= 1'b0;
      expected_seq_q     <= '0;
      expected_sub_seq_q <= '0;
      held_total_q       <= '0;
      write_pointer_q    <= '0;
      bytes_pending_q    <= '0;
      out_valid_q        <= 1'b0;
    end else begin
      if (accept) begin
        waiting_q          <= waiting_d;
        buffer_held_q      <= buffer_held_d;
        expected_seq_q     <= expected_seq_d;
        expected_sub_seq_q <= expected_sub_seq_d;
        held_total_q       <= held_total_d;
        write_pointer_q    <= write_pointer_d;
        bytes_pending_q    <= bytes_pending_d;
        out_valid_q        <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register, loaded with each accepted transaction.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q    <= out_d;
      rd_hit_q <= rd_hit;
    end
  end

  // Reassembly store: one write and one registered read per cycle at most.
  always_ff @(posedge clk_i) begin
    if (accept && mem_we) begin
      message_store[write_pointer_q[AW-1:0]] <= item.data_byte;
    end
    if (mem_re) begin
      rdata_q <= message_store[mem_raddr];
    end
  end

  // The stored byte joins the result as it leaves the memory's read register.
  always_comb begin
    out_o.payload           = out_q;
    out_o.payload.read_data = rd_hit_q ? rdata_q : 8'd0;
  end
  assign out_o.valid = out_valid_q;

  // Checks on the reassembly state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    waiting_q |-> buffer_held_q)
    else $error("Waiting for fragments without a held buffer.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_pointer_q <= held_total_q)
    else $error("Write pointer has run past the announced total length.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_pending_q <= held_total_q - write_pointer_q)
    else $error("Pending bytes exceed the room left in the message.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item.kind == KIND_HEADER && !item.header_ok) |=>
      ($stable(buffer_held_q) && $stable(write_pointer_q) && bytes_pending_q == '0))
    else $error("An unreadable header changed the message state.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item.kind == KIND_PAYLOAD && bytes_pending_q != '0) |=>
      (write_pointer_q == $past(write_pointer_q) + CW'(1)))
    else $error("A pending payload byte did not advance the write pointer.");

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench of the fragment reassembly engine with a built-in reassembly predictor.
`default_nettype none

module testbench
  import fre_pkg::*;
;

  // Fragment type outside the defined set, used to provoke the bad type status.
  localparam logic [2:0] FT_INVALID = 3'd7;
  // Number of random transactions after the directed part.
  localparam int unsigned RandomItems = 1700;

  // Predicts each result from the accepted transactions and checks the returned ones.
  class reassembly_scoreboard;
    bit              waiting;
    bit              held;
    bit [15:0]       exp_seq;
    bit [15:0]       exp_sub;
    int unsigned     held_total;
    int unsigned     wr_ptr;
    int unsigned     pending;
    bit [7:0]        store [StoreBytesDefault];
    fre_out_t        expected_q [$];
    int unsigned     failures;

    function void clear_state();
      waiting    = 1'b0;
      held       = 1'b0;
      exp_seq    = '0;
      exp_sub    = '0;
      held_total = 0;
      wr_ptr     = 0;
      pending    = 0;
    endfunction

    // Header checks in priority order; the pending bytes of the previous fragment are dropped.
    function status_e take_header(fre_in_t it);
      pending = 0;
      if (!it.header_ok) return ST_UNREADABLE;
      if (it.seq_number != exp_seq) return ST_SEQ;
      if (!(exp_sub == 0 && it.sub_seq_number == 0) &&
          ({1'b0, exp_sub} + 17'd1) != {1'b0, it.sub_seq_number}) return ST_SUBSEQ;
      if (it.frag_class > FT_END) return ST_BAD_TYPE;
      // The fragment type has to agree with the waiting and held flags.
      if (it.frag_class <= FT_START) begin
        if (held || waiting) begin
          clear_state();
          return ST_MISMATCH;
        end
      end else if (!held || !waiting) begin
        clear_state();
        return ST_MISMATCH;
      end
      // The first fragment fixes the total length; later ones must repeat it.
      if (!held) begin
        if (it.total_length > StoreBytesDefault) begin
          clear_state();
          return ST_TOO_LARGE;
        end
        held       = 1'b1;
        held_total = it.total_length;
        wr_ptr     = 0;
      end else if (it.total_length != held_total) begin
        clear_state();
        return ST_TOTAL;
      end
      if (it.payload_length > held_total - wr_ptr) begin
        clear_state();
        return ST_OVERFLOW;
      end
      pending = it.payload_length;
      case (it.frag_class)
        FT_START: begin
          waiting = 1'b1;
          exp_seq = it.seq_number;
          exp_sub = it.sub_seq_number;
        end
        FT_MID: begin
          exp_seq = it.seq_number;
          exp_sub = it.sub_seq_number;
        end
        FT_END: begin
          waiting = 1'b0;
        end
        default: begin
        end
      endcase
      return ST_OK;
    endfunction

    // Updates the predicted state for an accepted input and queues the expected result.
    function void note_input(fre_in_t it);
      fre_out_t want;
      status_e  st;
      bit [7:0] rd;
      bit       was_ready;
      st        = ST_OK;
      rd        = '0;
      was_ready = held && !waiting;
      case (it.kind)
        KIND_HEADER: begin
          st = take_header(it);
        end
        KIND_PAYLOAD: begin
          if (pending > 0 && wr_ptr < StoreBytesDefault) begin
            store[wr_ptr] = it.data_byte;
            wr_ptr++;
            pending--;
          end else begin
            st = ST_IGNORED;
          end
        end
        KIND_READ: begin
          if (was_ready && it.read_index < wr_ptr) rd = store[it.read_index];
          else st = ST_IGNORED;
        end
        default: begin
          if (was_ready) clear_state();
          else st = ST_IGNORED;
        end
      endcase
      want.status         = st;
      want.message_ready  = held && !waiting;
      want.message_length = 13'(wr_ptr);
      want.read_data      = rd;
      expected_q.push_back(want);
    endfunction

    // Compares a returned result with the oldest prediction.
    function void check_result(fre_out_t got);
      fre_out_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: status %0d ready %0b length %0d data %02h",
                   got.status, got.message_ready, got.message_length, got.read_data);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.message_ready !== want.message_ready ||
          got.message_length !== want.message_length || got.read_data !== want.read_data) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected %0d %0b %0d %02h, actual %0d %0b %0d %02h",
                   want.status, want.message_ready, want.message_length, want.read_data,
                   got.status, got.message_ready, got.message_length, got.read_data);
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  fre_stream_if #(.payload_t(fre_in_t))  in_if ();
  fre_stream_if #(.payload_t(fre_out_t)) out_if ();

  reassembly_scoreboard sb = new();
  int unsigned          sent;
  bit                   quiet;

  fragment_reassembly_engine DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Clock with a period of 12 time units.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Every returned transaction is checked at the edge that accepts it.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.payload);
  end

  // Result side: ready drops for random bursts until the quiet end phase.
  initial begin
    out_if.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // Every field random; callers overwrite the fields that matter to them.
  function automatic fre_in_t random_item();
    fre_in_t it;
    it.kind           = 2'($urandom);
    it.header_ok      = 1'($urandom);
    it.frag_class     = 3'($urandom);
    it.seq_number     = 16'($urandom);
    it.sub_seq_number = 16'($urandom);
    it.total_length   = $urandom;
    it.payload_length = $urandom;
    it.data_byte      = 8'($urandom);
    it.read_index     = 12'($urandom);
    return it;
  endfunction

  // A sub-sequence number that passes the check in the current state.
  function automatic logic [15:0] next_sub();
    if (sb.exp_sub == 0 && $urandom_range(0, 1) == 1) return '0;
    return sb.exp_sub + 16'd1;
  endfunction

  // Offers one transaction, possibly after a random gap, and records it once accepted.
  task automatic send(fre_in_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(it);
    sent++;
  endtask

  // Holds the input idle until every predicted result has been returned.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
  endtask

  task automatic hdr(bit ok, logic [2:0] ft, logic [15:0] seq, logic [15:0] sub,
                     logic [31:0] total, logic [31:0] payload);
    fre_in_t it;
    it                = random_item();
    it.kind           = KIND_HEADER;
    it.header_ok      = ok;
    it.frag_class     = ft;
    it.seq_number     = seq;
    it.sub_seq_number = sub;
    it.total_length   = total;
    it.payload_length = payload;
    send(it);
  endtask

  task automatic put_byte(logic [7:0] data);
    fre_in_t it;
    it           = random_item();
    it.kind      = KIND_PAYLOAD;
    it.data_byte = data;
    send(it);
  endtask

  task automatic read_at(logic [11:0] idx);
    fre_in_t it;
    it            = random_item();
    it.kind       = KIND_READ;
    it.read_index = idx;
    send(it);
  endtask

  task automatic release_msg();
    fre_in_t it;
    it      = random_item();
    it.kind = KIND_RELEASE;
    send(it);
  endtask

  // Broken or stray transactions: random items, doubtful headers, stray bytes, reads, releases.
  task automatic noise();
    fre_in_t it;
    it = random_item();
    case ($urandom_range(0, 3))
      0: begin
      end
      1: begin
        it.kind           = KIND_HEADER;
        it.header_ok      = ($urandom_range(0, 7) != 0);
        it.seq_number     = sb.exp_seq;
        it.sub_seq_number = next_sub();
        case ($urandom_range(0, 2))
          0: it.total_length = $urandom;
          1: it.total_length = $urandom_range(0, 64);
          default: it.total_length = sb.held_total;
        endcase
        it.payload_length = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 64);
      end
      2: it.kind = ($urandom_range(0, 1) == 1) ? KIND_PAYLOAD : KIND_READ;
      default: it.kind = KIND_RELEASE;
    endcase
    send(it);
  endtask

  // One message split into fragments with random content, then up to three reads and mostly a release.
  task automatic send_message(int unsigned total, int unsigned frags);
    int unsigned left;
    int unsigned part;
    logic [2:0]  ft;
    left = total;
    for (int f = 0; f < frags; f++) begin
      if ($urandom_range(0, 39) == 0) noise();
      if (frags == 1) ft = FT_START_END;
      else if (f == 0) ft = FT_START;
      else if (f == frags - 1) ft = FT_END;
      else ft = FT_MID;
      part = (f == frags - 1) ? left : $urandom_range(0, left);
      left -= part;
      hdr(1'b1, ft, sb.exp_seq, next_sub(), total, part);
      repeat (part) put_byte(8'($urandom));
      // Now and then a byte beyond the announced payload.
      if ($urandom_range(0, 19) == 0) put_byte(8'($urandom));
    end
    repeat ($urandom_range(0, 3)) read_at(12'($urandom_range(0, total)));
    if ($urandom_range(0, 9) != 0) release_msg();
  endtask

  // Stimulus: directed cases, messages at the store size limit, then random traffic.
  initial begin : stimulus
    int unsigned base;
    in_if.valid   <= 1'b0;
    in_if.payload <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Rejected headers that leave the state alone, then a mid fragment with no message.
    hdr(1'b0, FT_START_END, 16'h0000, 16'h0000, 32'd4, 32'd4);
    hdr(1'b1, FT_START_END, 16'hFFFF, 16'h0000, 32'd4, 32'd4);
    hdr(1'b1, FT_START_END, 16'h0000, 16'hFFFF, 32'd4, 32'd4);
    hdr(1'b1, FT_INVALID, 16'h0000, 16'h0000, 32'd4, 32'd4);
    hdr(1'b1, FT_MID, 16'h0000, 16'h0000, 32'd0, 32'd0);
    // Total length beyond the store, stray byte, read and release with no message.
    hdr(1'b1, FT_START_END, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 32'd0);
    put_byte(8'hA5);
    read_at(12'hFFF);
    release_msg();
    // Payload longer than the room left.
    hdr(1'b1, FT_START_END, 16'h0000, 16'h0000, 32'd4, 32'hFFFF_FFFF);
    // Start while a message is held.
    hdr(1'b1, FT_START, 16'h0000, 16'h0001, 32'd3, 32'd1);
    put_byte(8'hFF);
    hdr(1'b1, FT_START, 16'h0000, 16'h0002, 32'd3, 32'd1);
    // Pending bytes dropped by the next header, then a total that disagrees.
    hdr(1'b1, FT_START, 16'h0000, 16'h0000, 32'd3, 32'd2);
    hdr(1'b1, FT_MID, 16'h0000, 16'h0001, 32'd3, 32'd1);
    put_byte(8'h5A);
    hdr(1'b1, FT_MID, 16'h0000, 16'h0002, 32'd5, 32'd1);
    // A complete single-fragment message, an extra byte, reads in and out of range.
    hdr(1'b1, FT_START_END, 16'h0000, 16'h0000, 32'd2, 32'd2);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'h33);
    read_at(12'd1);
    read_at(12'd2);
    release_msg();

    drain_results();
    // A message announced at the full store size, then one a byte larger than the store.
    hdr(1'b1, FT_START, sb.exp_seq, next_sub(), StoreBytesDefault, 32'd16);
    repeat (16) put_byte(8'($urandom));
    hdr(1'b1, FT_END, sb.exp_seq, next_sub(), StoreBytesDefault, 32'd0);
    read_at(12'd15);
    read_at(12'd16);
    release_msg();
    hdr(1'b1, FT_START_END, sb.exp_seq, next_sub(), StoreBytesDefault + 1, 32'd0);

    base = sent;
    while (sent - base < RandomItems) begin
      if ($urandom_range(0, 99) < 75)
        send_message(($urandom_range(0, 9) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 24),
                     $urandom_range(1, 4));
      else
        repeat ($urandom_range(1, 4)) noise();
      if ($urandom_range(0, 49) == 0) drain_results();
      if (sent - base > RandomItems - 150) quiet = 1'b1;
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (sb.failures == 0 && sb.expected_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run.
  initial begin
    #12_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
sv/fre_pkg.sv
sv/fre_stream_if.sv
sv/fragment_reassembly_engine.sv
sim/testbench.sv
